FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/dsrp_pkg.sv
// ----------------------------------------------------------------------------
// dsrp_pkg
// constants, codes and helpers of the dual servo ramp positioner
// ----------------------------------------------------------------------------
package dsrp_pkg;

	// ramp length and field widths
	localparam int RAMP_STEPS = 100;
	localparam int STEP_W     = 7;
	localparam int ANG_W      = 8;
	localparam int PROD_W     = STEP_W + ANG_W;
	localparam int REM_W      = 7;
	localparam int DUTY_W     = 8;
	localparam int DUTY_QW    = 7;
	localparam int DREM_W     = 5;
	localparam int SEED_W     = 11;
	localparam int CNT_W      = 3;

	localparam logic [STEP_W:0]    STEPS_CMP = (STEP_W + 1)'(RAMP_STEPS);
	localparam logic [ANG_W-1:0]   ANGLE_MAX = 8'd180;
	localparam logic [DUTY_W-1:0]  DUTY_MIN  = 8'd20;
	localparam logic [DUTY_W-1:0]  DUTY_MAX  = 8'd130;
	// duty = angle * 11 / 18 + 20, the reduced form of angle * 110 / 180
	localparam logic [DREM_W:0]    DUTY_DIV  = 6'd18;

	// serial phase lengths
	localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(STEP_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(ANG_W - 1);
	localparam logic [CNT_W-1:0] DUTY_LAST = CNT_W'(DUTY_QW - 1);

	// register reset values
	localparam logic [ANG_W-1:0] OPEN_LEFT_RST   = 8'd90;
	localparam logic [ANG_W-1:0] OPEN_RIGHT_RST  = 8'd0;
	localparam logic [ANG_W-1:0] CLOSE_LEFT_RST  = 8'd45;
	localparam logic [ANG_W-1:0] CLOSE_RIGHT_RST = 8'd45;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_SET_LEFT  = 3'd1,
		OP_SET_RIGHT = 3'd2,
		OP_OPEN      = 3'd3,
		OP_CLOSE     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CFG_OPEN_LEFT   = 2'd0,
		CFG_OPEN_RIGHT  = 2'd1,
		CFG_CLOSE_LEFT  = 2'd2,
		CFG_CLOSE_RIGHT = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SEED,
		ST_DUTY,
		ST_OUT
	} state_t;

	// angle * 11 by shift and add
	function automatic logic [SEED_W-1:0] duty_seed(input logic [ANG_W-1:0] a);
		logic [SEED_W-1:0] w;
		w = SEED_W'(a);
		return (w << 3) + (w << 1) + w;
	endfunction

	// clamp a signed request to 0..180
	function automatic logic [ANG_W-1:0] clamp_req(input logic signed [ANG_W:0] a);
		logic [ANG_W-1:0] r;
		if (a[ANG_W])
			r = '0;
		else if (a[ANG_W-1:0] > ANGLE_MAX)
			r = ANGLE_MAX;
		else
			r = a[ANG_W-1:0];
		return r;
	endfunction

endpackage

FILE: rtl/core/dual_servo_ramp_pwm.sv
// ----------------------------------------------------------------------------
// dual_servo_ramp_pwm
// two-channel servo positioner: set commands, linear open/close ramps and
// angle to PWM duty conversion, worked out bit-serially on two lanes
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+-----------
//  in      | in_valid, in_ready, opcode, angle    | sink
//  out     | out_valid, out_ready, left_duty,     | source
//          | right_duty, ramp_busy, ramp_last     |
//  cfg     | cfg_valid, cfg_ready, cfg_index,     | sink
//          | cfg_data                             |
//
//  a beat that opens or continues a ramp runs the multiply, divide, seed and
//  duty steps, then one load into the output register; the last ramp step and
//  all other beats go straight to the duty divider; a new beat is taken only
//  after the output register is loaded; both lanes run the shift-add multiply
//  and the restoring divides in parallel
//  the output register holds a finished result while the next beat is taken
//  reset restores the register defaults and leaves the ramp idle
//  cfg is always ready and takes one write per cycle
// ----------------------------------------------------------------------------
module dual_servo_ramp_pwm
	import dsrp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              opcode,
	input  logic signed [ANG_W:0]   angle,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [DUTY_W-1:0]       left_duty,
	output logic [DUTY_W-1:0]       right_duty,
	output logic                    ramp_busy,
	output logic                    ramp_last,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [ANG_W-1:0]        cfg_data
);

`include "assert_macros.svh"

	// configuration, lane 0 left, lane 1 right
	logic [ANG_W-1:0] open_q [2];
	logic [ANG_W-1:0] close_q [2];

	// positioner state
	logic [ANG_W-1:0]  now_q [2];
	logic [ANG_W-1:0]  start_q [2];
	logic              closing_q;
	logic [STEP_W-1:0] step_q;
	logic              ramp_on_q;

	// serial datapath
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [STEP_W-1:0] mul_q;
	logic [PROD_W-1:0] acc_q [2];
	logic [ANG_W-1:0]  mag_q [2];
	logic              neg_q [2];
	logic [ANG_W-1:0]  base_q [2];
	logic [REM_W-1:0]  rem_q [2];
	logic              busy_q;
	logic              last_q;

	// output register
	logic              out_valid_q;
	logic [DUTY_W-1:0] left_duty_q;
	logic [DUTY_W-1:0] right_duty_q;
	logic              ramp_busy_q;
	logic              ramp_last_q;

	// beat decode
	logic              in_acc;
	logic              load_out;
	op_t               op;
	logic [ANG_W-1:0]  req_clamped;
	logic              starting;
	logic              ramp_act;
	logic              dir;
	logic [STEP_W-1:0] idx0;
	logic              adv;
	logic [STEP_W-1:0] idx_new;
	logic              fin;
	logic              direct;
	logic [ANG_W-1:0]  tgt [2];
	logic [ANG_W-1:0]  base_sel [2];
	logic [ANG_W-1:0]  show [2];
	logic [ANG_W:0]    diff [2];
	logic [SEED_W-1:0] dseed [2];

	// lane arithmetic
	logic [PROD_W-1:0] mul_nxt [2];
	logic [STEP_W:0]   div_trial [2];
	logic              div_ge [2];
	logic [REM_W-1:0]  div_rem [2];
	logic [ANG_W-1:0]  ang [2];
	logic [SEED_W-1:0] seed [2];
	logic [DREM_W:0]   dty_trial [2];
	logic              dty_ge [2];
	logic [DREM_W-1:0] dty_rem [2];

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign load_out  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	assign out_valid  = out_valid_q;
	assign left_duty  = left_duty_q;
	assign right_duty = right_duty_q;
	assign ramp_busy  = ramp_busy_q;
	assign ramp_last  = ramp_last_q;

	// command decode and ramp step selection
	always_comb begin
		op          = op_t'(opcode);
		req_clamped = clamp_req(angle);
		starting    = !ramp_on_q && (op == OP_OPEN || op == OP_CLOSE);
		ramp_act    = ramp_on_q || starting;
		dir         = starting ? (op == OP_CLOSE) : closing_q;
		idx0        = starting ? '0 : step_q;
		adv         = ramp_act && (op == OP_TICK || idx0 == '0);
		idx_new     = adv ? idx0 + STEP_W'(1) : idx0;
		fin         = adv && ({1'b0, idx_new} >= STEPS_CMP);
		direct      = fin || !ramp_act;
		for (int l = 0; l < 2; l++) begin
			tgt[l]      = dir ? close_q[l] : open_q[l];
			base_sel[l] = starting ? now_q[l] : start_q[l];
			diff[l]     = {1'b0, tgt[l]} - {1'b0, base_sel[l]};
			show[l]     = fin ? tgt[l] : now_q[l];
		end
		if (!ramp_act && op == OP_SET_LEFT)
			show[0] = req_clamped;
		if (!ramp_act && op == OP_SET_RIGHT)
			show[1] = req_clamped;
		for (int l = 0; l < 2; l++)
			dseed[l] = duty_seed(show[l]);
	end

	// per-lane multiply, divide and duty steps
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mul_nxt[l] = (acc_q[l] << 1)
				+ (mul_q[STEP_W-1] ? PROD_W'(mag_q[l]) : '0);
			div_trial[l] = {rem_q[l], acc_q[l][ANG_W-1]};
			div_ge[l]    = div_trial[l] >= STEPS_CMP;
			div_rem[l]   = div_ge[l] ? REM_W'(div_trial[l] - STEPS_CMP)
				: REM_W'(div_trial[l]);
			ang[l]     = neg_q[l] ? base_q[l] - acc_q[l][ANG_W-1:0]
				: base_q[l] + acc_q[l][ANG_W-1:0];
			seed[l]    = duty_seed(ang[l]);
			dty_trial[l] = {rem_q[l][DREM_W-1:0], acc_q[l][DUTY_QW-1]};
			dty_ge[l]    = dty_trial[l] >= DUTY_DIV;
			dty_rem[l]   = dty_ge[l] ? DREM_W'(dty_trial[l] - DUTY_DIV)
				: dty_trial[l][DREM_W-1:0];
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q + CNT_W'(1);
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (in_acc)
					state_d = direct ? ST_DUTY : ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == MUL_LAST) begin
					state_d = ST_DIV;
					cnt_d   = '0;
				end
			end
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = ST_SEED;
					cnt_d   = '0;
				end
			end
			ST_SEED: begin
				state_d = ST_DUTY;
				cnt_d   = '0;
			end
			ST_DUTY: begin
				if (cnt_q == DUTY_LAST) begin
					state_d = ST_OUT;
					cnt_d   = '0;
				end
			end
			ST_OUT: begin
				cnt_d = '0;
				if (load_out)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// configuration and positioner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q[0]  <= OPEN_LEFT_RST;
			open_q[1]  <= OPEN_RIGHT_RST;
			close_q[0] <= CLOSE_LEFT_RST;
			close_q[1] <= CLOSE_RIGHT_RST;
			now_q[0]   <= '0;
			now_q[1]   <= '0;
			start_q[0] <= '0;
			start_q[1] <= '0;
			closing_q  <= 1'b0;
			step_q     <= '0;
			ramp_on_q  <= 1'b0;
			busy_q     <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_OPEN_LEFT:   open_q[0]  <= (cfg_data > ANGLE_MAX) ? ANGLE_MAX : cfg_data;
					CFG_OPEN_RIGHT:  open_q[1]  <= (cfg_data > ANGLE_MAX) ? ANGLE_MAX : cfg_data;
					CFG_CLOSE_LEFT:  close_q[0] <= (cfg_data > ANGLE_MAX) ? ANGLE_MAX : cfg_data;
					CFG_CLOSE_RIGHT: close_q[1] <= (cfg_data > ANGLE_MAX) ? ANGLE_MAX : cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				busy_q <= ramp_act && !fin;
				last_q <= fin;
				if (fin) begin
					now_q[0]  <= tgt[0];
					now_q[1]  <= tgt[1];
					ramp_on_q <= 1'b0;
					step_q    <= '0;
				end else if (ramp_act) begin
					ramp_on_q <= 1'b1;
					step_q    <= idx_new;
					closing_q <= dir;
					if (starting) begin
						start_q[0] <= now_q[0];
						start_q[1] <= now_q[1];
					end
				end else begin
					now_q[0] <= show[0];
					now_q[1] <= show[1];
				end
			end
		end
	end

	// multiplier bits, msb first
	always_ff @(posedge clk) begin
		if (in_acc)
			mul_q <= idx_new;
		else if (state_q == ST_MUL)
			mul_q <= {mul_q[STEP_W-2:0], 1'b0};
	end

	// lane datapath
	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && direct) begin
						rem_q[l]              <= REM_W'(dseed[l][SEED_W-1:DUTY_QW]);
						acc_q[l][DUTY_QW-1:0] <= dseed[l][DUTY_QW-1:0];
					end else if (in_acc) begin
						acc_q[l]  <= '0;
						neg_q[l]  <= diff[l][ANG_W];
						mag_q[l]  <= diff[l][ANG_W] ? ANG_W'(~diff[l] + 1'b1)
							: diff[l][ANG_W-1:0];
						base_q[l] <= base_sel[l];
					end
				end
				ST_MUL: begin
					acc_q[l] <= mul_nxt[l];
					if (cnt_q == MUL_LAST)
						rem_q[l] <= mul_nxt[l][PROD_W-1:ANG_W];
				end
				ST_DIV: begin
					rem_q[l]            <= div_rem[l];
					acc_q[l][ANG_W-1:0] <= {acc_q[l][ANG_W-2:0], div_ge[l]};
				end
				ST_SEED: begin
					rem_q[l]              <= REM_W'(seed[l][SEED_W-1:DUTY_QW]);
					acc_q[l][DUTY_QW-1:0] <= seed[l][DUTY_QW-1:0];
				end
				ST_DUTY: begin
					rem_q[l]              <= REM_W'(dty_rem[l]);
					acc_q[l][DUTY_QW-1:0] <= {acc_q[l][DUTY_QW-2:0], dty_ge[l]};
				end
				default: ;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			left_duty_q  <= DUTY_MIN + DUTY_W'(acc_q[0][DUTY_QW-1:0]);
			right_duty_q <= DUTY_MIN + DUTY_W'(acc_q[1][DUTY_QW-1:0]);
			ramp_busy_q  <= busy_q;
			ramp_last_q  <= last_q;
		end
	end

	// checks
	`ASSERT_NEXT(a_accept_leaves_idle, in_acc, !in_ready)
	`ASSERT_IMPL(a_step_in_ramp, ramp_on_q, (step_q != '0) && ({1'b0, step_q} < STEPS_CMP))
	`ASSERT_IMPL(a_step_idle_zero, !ramp_on_q, step_q == '0)
	`ASSERT_IMPL(a_last_not_busy, out_valid_q && ramp_last_q, !ramp_busy_q)
	`ASSERT_IMPL(a_left_range, out_valid_q, (left_duty_q >= DUTY_MIN) && (left_duty_q <= DUTY_MAX))
	`ASSERT_IMPL(a_right_range, out_valid_q, (right_duty_q >= DUTY_MIN) && (right_duty_q <= DUTY_MAX))

endmodule
